### hw/rtl/aht_pkg.sv
// Shared types and constants for the averaging hysteresis thermostat.
package aht_pkg;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_HIGH = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_MODE   = 1'b1;

  localparam logic REG_LOW_SET_POINT  = 1'b0;
  localparam logic REG_HIGH_SET_POINT = 1'b1;

  localparam int TEMP_W   = 7;
  localparam int SAMPLE_W = 12;

  // Accepted window, exclusive, in 1/16 C: -10 C and 38 C.
  localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RAW  = -12'sd160;
  localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT_RAW = 12'sd608;

  localparam logic [TEMP_W-1:0] COLD_LIMIT_F = 7'd40;
  localparam logic [TEMP_W:0]   HYSTERESIS_F = 8'd3;

  // F = floor((raw * 9 + 2560) / 80); /80 done as >>4 then /5 by reciprocal.
  localparam logic [14:0] F_OFFSET = 15'd2560;
  localparam logic [7:0]  DIV5_MUL = 8'd205;
  localparam int          DIV5_SHR = 10;

endpackage

### hw/rtl/averaging_hysteresis_thermostat.sv
// Averaging thermostat with hysteresis heater control, top level.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in_     | input     | in_valid / in_ready    | operation, sample_temp, crc_ok, new_mode
//  out_    | output    | out_valid / out_ready  | heater_on, average_valid,
//          |           |                        | average_temp_f, cold_warning,
//          |           |                        | request_rejected
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle in while the output is not stalled, one result word per input word,
// through the input register, the reading conversion register, then the state update
// into the output register. The state loop (sum, average by reciprocal multiply, heater
// compare) is combinational from the state registers, so words follow back to back.
// rst_n is synchronous and clears all control state; no clearing pass.
// A stalled output holds the pipe; in_ready drops only when all stages are full.
module averaging_hysteresis_thermostat
  import aht_pkg::*;
#(
  parameter int SAMPLES_PER_AVERAGE = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic signed [SAMPLE_W-1:0] in_sample_temp,
  input  logic                       in_crc_ok,
  input  logic [1:0]                 in_new_mode,

  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_heater_on,
  output logic                       out_average_valid,
  output logic [TEMP_W-1:0]          out_average_temp_f,
  output logic                       out_cold_warning,
  output logic                       out_request_rejected,

  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [TEMP_W-1:0]          cfg_data
);

  localparam int MAX_F   = 100;
  localparam int SUM_W   = $clog2(SAMPLES_PER_AVERAGE * MAX_F + 1);
  localparam int CNT_W   = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam int AVG_SHR = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int RECIP_W = AVG_SHR + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SHR) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  // pipeline control
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic adv3, adv2, adv1;

  assign adv3     = !out_valid_r || out_ready;
  assign adv2     = !s2_valid_r || adv3;
  assign adv1     = !s1_valid_r || adv2;
  assign in_ready = adv1;
  assign cfg_ready = 1'b1;

  // stage 1: input register
  logic                       s1_op_r;
  logic signed [SAMPLE_W-1:0] s1_temp_r;
  logic                       s1_crc_r;
  logic [1:0]                 s1_mode_r;

  // stage 2: converted reading
  logic              s2_op_r;
  logic              s2_keep_r;
  logic [TEMP_W-1:0] s2_f_r;
  logic [1:0]        s2_mode_r;

  // configuration and state
  logic [TEMP_W-1:0] low_sp_r, high_sp_r;
  mode_t             heat_mode_r, heat_mode_nxt;
  logic [TEMP_W-1:0] active_sp_r, active_sp_nxt;
  logic              heater_r, heater_nxt;
  logic              warn_sent_r, warn_sent_nxt;
  logic [TEMP_W-1:0] cur_temp_r, cur_temp_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic out_heater_r, out_avg_valid_r, out_cold_r, out_rej_r;
  logic avg_valid_nxt, cold_nxt, rej_nxt;
  logic [TEMP_W-1:0] out_temp_r;

  // reading conversion (stage 1 -> 2)
  logic signed [14:0] scaled;
  logic [8:0]         div16;
  logic [16:0]        div5_prod;
  logic               keep;

  always_comb begin
    scaled = (15'(s1_temp_r) <<< 3) + 15'(s1_temp_r) + $signed(F_OFFSET);
    div16 = scaled[12:4];
    div5_prod = 17'(div16) * 17'(DIV5_MUL);
    keep = s1_crc_r && (s1_temp_r > LOW_LIMIT_RAW) && (s1_temp_r < HIGH_LIMIT_RAW);
  end

  // state update (stage 2 -> output)
  logic [SUM_W-1:0]         sum_add;
  logic [SUM_W+RECIP_W-1:0] avg_prod;
  logic [TEMP_W-1:0]        avg;
  logic                     do_eval;
  logic [TEMP_W-1:0]        eval_temp;

  always_comb begin
    sum_add  = sum_r + SUM_W'(s2_f_r);
    avg_prod = (SUM_W+RECIP_W)'(sum_add) * (SUM_W+RECIP_W)'(AVG_RECIP);
    avg      = avg_prod[AVG_SHR +: TEMP_W];

    heat_mode_nxt = heat_mode_r;
    active_sp_nxt = active_sp_r;
    heater_nxt    = heater_r;
    warn_sent_nxt = warn_sent_r;
    cur_temp_nxt  = cur_temp_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    avg_valid_nxt = 1'b0;
    cold_nxt      = 1'b0;
    rej_nxt       = 1'b0;
    do_eval       = 1'b0;

    if (s2_op_r == OP_SAMPLE) begin
      if (s2_keep_r) begin
        if (cnt_r == LAST_COUNT) begin
          avg_valid_nxt = 1'b1;
          sum_nxt = '0;
          cnt_nxt = '0;
          if (avg != cur_temp_r) begin
            cur_temp_nxt = avg;
            if (heat_mode_r == MODE_OFF) begin
              if (avg < COLD_LIMIT_F && !warn_sent_r) begin
                cold_nxt      = 1'b1;
                warn_sent_nxt = 1'b1;
              end
            end else begin
              do_eval = 1'b1;
            end
          end
        end else begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end else begin
      unique case (mode_t'(s2_mode_r))
        MODE_OFF: begin
          heater_nxt    = 1'b0;
          heat_mode_nxt = MODE_OFF;
        end
        MODE_LOW: begin
          active_sp_nxt = low_sp_r;
          heat_mode_nxt = MODE_LOW;
          do_eval       = 1'b1;
        end
        MODE_HIGH: begin
          active_sp_nxt = high_sp_r;
          heat_mode_nxt = MODE_HIGH;
          do_eval       = 1'b1;
        end
        default: rej_nxt = 1'b1;
      endcase
    end

    // hysteresis: off above set point, on below set point minus 3
    eval_temp = cur_temp_nxt;
    if (do_eval) begin
      if (eval_temp > active_sp_nxt) begin
        heater_nxt = 1'b0;
      end else if ({1'b0, eval_temp} + HYSTERESIS_F < {1'b0, active_sp_nxt} && !heater_r) begin
        heater_nxt    = 1'b1;
        warn_sent_nxt = 1'b0;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      low_sp_r    <= '0;
      high_sp_r   <= '0;
      heat_mode_r <= MODE_OFF;
      active_sp_r <= '0;
      heater_r    <= 1'b0;
      warn_sent_r <= 1'b0;
      cur_temp_r  <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (adv1) s1_valid_r <= in_valid;
      if (adv2) s2_valid_r <= s1_valid_r;
      if (adv3) out_valid_r <= s2_valid_r;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOW_SET_POINT:  low_sp_r  <= cfg_data;
          REG_HIGH_SET_POINT: high_sp_r <= cfg_data;
          default: ;
        endcase
      end
      if (s2_valid_r && adv3) begin
        heat_mode_r <= heat_mode_nxt;
        active_sp_r <= active_sp_nxt;
        heater_r    <= heater_nxt;
        warn_sent_r <= warn_sent_nxt;
        cur_temp_r  <= cur_temp_nxt;
        sum_r       <= sum_nxt;
        cnt_r       <= cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_op_r   <= in_operation;
      s1_temp_r <= in_sample_temp;
      s1_crc_r  <= in_crc_ok;
      s1_mode_r <= in_new_mode;
    end
    if (adv2 && s1_valid_r) begin
      s2_op_r   <= s1_op_r;
      s2_keep_r <= keep;
      s2_f_r    <= div5_prod[DIV5_SHR +: TEMP_W];
      s2_mode_r <= s1_mode_r;
    end
    if (adv3 && s2_valid_r) begin
      out_heater_r    <= heater_nxt;
      out_avg_valid_r <= avg_valid_nxt;
      out_temp_r      <= cur_temp_nxt;
      out_cold_r      <= cold_nxt;
      out_rej_r       <= rej_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_heater_on        = out_heater_r;
  assign out_average_valid    = out_avg_valid_r;
  assign out_average_temp_f   = out_temp_r;
  assign out_cold_warning     = out_cold_r;
  assign out_request_rejected = out_rej_r;

endmodule
